>>> src/stk_pkg.sv
// shared constants, types and control codes for the streaming top-k tracker
package stk_pkg;

	localparam int VALUE_W      = 31;
	localparam int KEEP_W       = 7;
	localparam int CAPACITY_DEF = 64;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd8;

	// per-cycle commands broadcast along the cell chain
	typedef struct packed {
		logic insert;
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

>>> src/stk_if.sv
// valid/ready channel interfaces for offered items and query results

interface stk_item_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [stk_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface stk_res_if;
	logic                          valid;
	logic                          ready;
	logic [stk_pkg::VALUE_W-1:0]   result_value;
	logic                          empty_res;
	logic                          last;

	modport source (output valid, output result_value, output empty_res, output last,
		input ready);
	modport sink   (input valid, input result_value, input empty_res, input last,
		output ready);
endinterface

>>> src/stk_cell.sv
// one slot of the sorted chain: a kept value plus a readout copy
module stk_cell (
	input  logic                        clk,
	input  stk_pkg::cell_ctl_t          ctl,
	input  logic [stk_pkg::VALUE_W-1:0] v,
	input  logic                        valid,
	input  logic                        prev_gt,
	input  logic [stk_pkg::VALUE_W-1:0] prev_val,
	input  logic [stk_pkg::VALUE_W-1:0] next_scr,
	output logic                        gt,
	output logic [stk_pkg::VALUE_W-1:0] kept_val,
	output logic [stk_pkg::VALUE_W-1:0] scr_val
);

	logic [stk_pkg::VALUE_W-1:0] kept_q;
	logic [stk_pkg::VALUE_W-1:0] scr_q;

	// an empty slot counts as smaller than anything
	assign gt = !valid || (v > kept_q);

	// insertion: upper neighbor if the item lands above, the item if it lands here, else hold
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (prev_gt) begin
				kept_q <= prev_val;
			end else if (gt) begin
				kept_q <= v;
			end
		end
	end

	// readout copy, shifted toward the head one slot per result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			scr_q <= kept_q;
		end else if (ctl.shift) begin
			scr_q <= next_scr;
		end
	end

	assign kept_val = kept_q;
	assign scr_val  = scr_q;

endmodule

>>> src/streaming_top_k_tracker_top.sv
// top level: control, configuration register and the chain of sorted cells
//
// channel  dir  handshake      payload
// item     in   valid/ready    op, value
// res      out  valid/ready    result_value, empty_res, last
// cfg      in   cfg_we         cfg_data (keep_count)
//
// On an offer, every cell compares against the item at once and
// the chain shifts by one slot below the insertion point.
// A query copies the chain, then yields one result per held value
// (one for an empty store), paced by the result register; items wait meanwhile.
// Reset clears the held count, the state and the result register; keep_count
// returns to 8. A stalled result holds the readout shift in place.
module streaming_top_k_tracker_top #(
	parameter int CAPACITY = stk_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	stk_item_if.sink                    item,
	stk_res_if.source                   res,
	input  logic                        cfg_we,
	input  logic [stk_pkg::KEEP_W-1:0]  cfg_data
);

	localparam int HW = $clog2(CAPACITY + 1);
	localparam int VW = stk_pkg::VALUE_W;
	localparam int KW = stk_pkg::KEEP_W;

	stk_pkg::state_t    state_q;
	stk_pkg::state_t    state_nxt;
	stk_pkg::cell_ctl_t ctl;

	logic [KW-1:0] keep_q;
	logic [KW-1:0] k_eff;
	logic [HW-1:0] held_q;
	logic [HW-1:0] rem_q;
	logic          empty_q;
	logic          accept;
	logic          grow;
	logic          emit;

	logic          out_valid_q;
	logic [VW-1:0] out_value_q;
	logic          out_empty_q;
	logic          out_last_q;

	logic [VW-1:0] kept_w [CAPACITY];
	logic [VW-1:0] scr_w  [CAPACITY];
	logic          gt_w   [CAPACITY];

	// keep_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= stk_pkg::KEEP_RESET;
		end else if (cfg_we) begin
			keep_q <= cfg_data;
		end
	end

	// effective k: zero means one, above capacity saturates
	always_comb begin
		if (keep_q == '0) begin
			k_eff = KW'(1);
		end else if (keep_q > KW'(CAPACITY)) begin
			k_eff = KW'(CAPACITY);
		end else begin
			k_eff = keep_q;
		end
	end

	assign accept = item.valid && item.ready;
	assign grow   = (KW'(held_q) < k_eff) && (held_q < HW'(CAPACITY));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			stk_pkg::ST_IDLE: begin
				if (accept && item.op) begin
					state_nxt = stk_pkg::ST_DRAIN;
				end
			end
			stk_pkg::ST_DRAIN: begin
				if (emit && rem_q == HW'(1)) begin
					state_nxt = stk_pkg::ST_IDLE;
				end
			end
			default: state_nxt = stk_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item.ready = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			stk_pkg::ST_IDLE:  item.ready = 1'b1;
			stk_pkg::ST_DRAIN: emit = !out_valid_q || res.ready;
			default: begin
				item.ready = 1'b0;
				emit       = 1'b0;
			end
		endcase
		ctl.insert = accept && !item.op;
		ctl.load   = accept && item.op;
		ctl.shift  = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stk_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// held count and remaining results of the current answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			rem_q   <= '0;
			empty_q <= 1'b0;
		end else begin
			if (ctl.insert && grow) begin
				held_q <= held_q + HW'(1);
			end
			if (ctl.load) begin
				rem_q   <= (held_q == '0) ? HW'(1) : held_q;
				empty_q <= (held_q == '0);
			end else if (emit) begin
				rem_q <= rem_q - HW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= empty_q ? '0 : scr_w[0];
			out_empty_q <= empty_q;
			out_last_q  <= (rem_q == HW'(1));
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_value = out_value_q;
	assign res.empty_res    = out_empty_q;
	assign res.last         = out_last_q;

	// chain of cells, largest value at the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          prev_gt;
		logic [VW-1:0] prev_val;
		logic [VW-1:0] next_scr;

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_val = '0;
		end else begin : g_body
			assign prev_gt  = gt_w[i-1];
			assign prev_val = kept_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_scr = '0;
		end else begin : g_mid
			assign next_scr = scr_w[i+1];
		end

		stk_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.v        (item.value),
			.valid    (held_q > HW'(i)),
			.prev_gt  (prev_gt),
			.prev_val (prev_val),
			.next_scr (next_scr),
			.gt       (gt_w[i]),
			.kept_val (kept_w[i]),
			.scr_val  (scr_w[i])
		);
	end

endmodule
